/* src/hwfva_pkg.sv */
// Shared types, constants and float conversion functions for the packed half-width float adder.
`timescale 1ns / 1ps

package hwfva_pkg;

  // Vector geometry.
  localparam int MAX_LANES = 4;
  localparam int DEF_LANES = 4;
  localparam int ELEM_W    = 16;
  localparam int VEC_W     = MAX_LANES * ELEM_W;

  // Pipeline depth: five lane stages plus the merged output register.
  localparam int LANE_STAGES = 5;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  // Aligned significand: hidden bit, 23 fraction bits, guard, round, sticky.
  localparam int MANT_EXT_W = 27;
  localparam int SUM_W      = MANT_EXT_W + 1;
  localparam int LZ_W       = 5;
  localparam int EXP_W      = 10;

  // Element format codes.
  localparam logic WF_BF16 = 1'b0;
  localparam logic WF_HALF = 1'b1;

  // Single precision constants.
  localparam logic [31:0] BF16_ROUND_ADD = 32'h0000_8000;
  localparam logic [31:0] QNAN_BIT       = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN    = 32'hFFC0_0000;
  localparam logic [30:0] INF_MAG        = 31'h7F80_0000;

  // Control bundle from the pipeline controller to the lanes.
  typedef struct packed {
    logic [PIPE_STAGES-1:0] adv;
    logic                   wire_format;
  } pipe_ctl_t;

  // Exact widening of an IEEE half value to single precision.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [7:0] ex;
    logic [9:0] fr;
    logic       found;
    s     = h[15];
    e     = h[14:10];
    m     = h[9:0];
    ex    = 8'd0;
    fr    = 10'd0;
    found = 1'b0;
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      // Subnormal: renormalize around the leading one.
      for (int p = 9; p >= 0; p--) begin
        if (!found && m[p]) begin
          found = 1'b1;
          ex    = 8'(103 + p);
          fr    = 10'(m << (10 - p));
        end
      end
      return {s, ex, fr, 13'd0};
    end
    if (e == 5'h1F) return {s, 8'hFF, m, 13'd0};
    return {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

  // Narrowing to IEEE half with round to nearest even.
  function automatic logic [15:0] f32_to_half(input logic [31:0] x);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [4:0]  e5;
    logic [14:0] val;
    logic [12:0] rem;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [23:0] rem24;
    logic [23:0] half24;
    logic [10:0] sval;
    s  = x[31];
    ex = x[30:23];
    m  = x[22:0];
    if (ex == 8'hFF) begin
      if (m != 23'd0) return {s, 5'h1F, m[22:13] | 10'h200};
      return {s, 5'h1F, 10'd0};
    end
    if (ex == 8'd0) return {s, 15'd0};
    if (ex >= 8'd143) return {s, 5'h1F, 10'd0};
    if (ex >= 8'd113) begin
      e5  = 5'(ex - 8'd112);
      val = {e5, m[22:13]};
      rem = m[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && val[0])) val = val + 15'd1;
      return {s, val};
    end
    if (ex < 8'd102) return {s, 15'd0};
    // Result lands in the half subnormal range.
    full   = {1'b1, m};
    sh     = 5'(8'd126 - ex);
    sval   = 11'(full >> sh);
    rem24  = full & ((24'd1 << sh) - 24'd1);
    half24 = 24'd1 << (sh - 5'd1);
    if (rem24 > half24 || (rem24 == half24 && sval[0])) sval = sval + 11'd1;
    return {s, 4'd0, sval};
  endfunction

  // Narrowing to bfloat16: add half an ulp and keep the upper half.
  function automatic logic [15:0] narrow_bf16(input logic [31:0] x);
    logic [31:0] t;
    t = x + BF16_ROUND_ADD;
    return t[31:16];
  endfunction

  // Leading zero count of the unnormalized significand.
  function automatic logic [LZ_W-1:0] clz_ext(input logic [MANT_EXT_W-1:0] v);
    logic [LZ_W-1:0] n;
    logic            found;
    n     = LZ_W'(MANT_EXT_W);
    found = 1'b0;
    for (int i = MANT_EXT_W - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n     = LZ_W'(MANT_EXT_W - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

/* src/hwfva_lane.sv */
// One lane: five-stage single precision adder with widening and narrowing.
`timescale 1ns / 1ps

module hwfva_lane (
  input  logic                           clk,
  input  hwfva_pkg::pipe_ctl_t           ctl,
  input  logic [hwfva_pkg::ELEM_W-1:0]   acc_elem,
  input  logic [hwfva_pkg::ELEM_W-1:0]   add_elem,
  output logic [hwfva_pkg::ELEM_W-1:0]   sum_elem
);
  import hwfva_pkg::*;

  logic [31:0] a1_r, b1_r;
  logic [31:0] a_w, b_w;

  logic [31:0]           spec2_r, spec_nxt;
  logic                  isspec2_r, isspec_nxt;
  logic                  sign2_r, zsign2_r, sub2_r;
  logic [7:0]            exp2_r;
  logic [MANT_EXT_W-1:0] ml2_r, ms2_r, ms_nxt;
  logic                  swap;
  logic [31:0]           big, lit;
  logic [7:0]            d;
  logic [MANT_EXT_W-1:0] sm;
  logic                  nan_a, nan_b, inf_a, inf_b;

  logic [31:0]      spec3_r;
  logic             isspec3_r, sign3_r, zsign3_r;
  logic [7:0]       exp3_r;
  logic [SUM_W-1:0] sum3_r, sum_nxt;

  logic [31:0]           spec4_r;
  logic                  isspec4_r, sign4_r, zsign4_r, zero4_r;
  logic [MANT_EXT_W-1:0] nm4_r, nm_nxt;
  logic signed [EXP_W-1:0] ne4_r, ne_nxt;
  logic [LZ_W-1:0]       lz;

  logic [31:0]             s5_r, s5_nxt;
  logic                    rup;
  logic [24:0]             rnd;
  logic signed [EXP_W-1:0] er;

  // Stage 1: widen both operands; bfloat16 denormals read as signed zero.
  always_comb begin
    if (ctl.wire_format == WF_HALF) begin
      a_w = half_to_f32(acc_elem);
      b_w = half_to_f32(add_elem);
    end else begin
      a_w = (acc_elem[14:7] == 8'd0) ? {acc_elem[15], 31'd0} : {acc_elem, 16'd0};
      b_w = (add_elem[14:7] == 8'd0) ? {add_elem[15], 31'd0} : {add_elem, 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      a1_r <= a_w;
      b1_r <= b_w;
    end
  end

  // Stage 2: special operands, order by magnitude and align the smaller one.
  always_comb begin
    nan_a = (a1_r[30:23] == 8'hFF) && (a1_r[22:0] != 23'd0);
    nan_b = (b1_r[30:23] == 8'hFF) && (b1_r[22:0] != 23'd0);
    inf_a = (a1_r[30:0] == INF_MAG);
    inf_b = (b1_r[30:0] == INF_MAG);
    isspec_nxt = nan_a | nan_b | inf_a | inf_b;
    if (nan_a) spec_nxt = a1_r | QNAN_BIT;
    else if (nan_b) spec_nxt = b1_r | QNAN_BIT;
    else if (inf_a && inf_b && a1_r != b1_r) spec_nxt = DEFAULT_NAN;
    else if (inf_a) spec_nxt = a1_r;
    else spec_nxt = b1_r;

    swap = b1_r[30:0] > a1_r[30:0];
    big  = swap ? b1_r : a1_r;
    lit  = swap ? a1_r : b1_r;
    d    = big[30:23] - lit[30:23];
    sm   = {(lit[30:23] != 8'd0), lit[22:0], 3'b000};
    if (d >= 8'(MANT_EXT_W)) begin
      ms_nxt = {{(MANT_EXT_W-1){1'b0}}, |sm};
    end else begin
      ms_nxt = (sm >> d) |
               {{(MANT_EXT_W-1){1'b0}}, |(sm & ~({MANT_EXT_W{1'b1}} << d))};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      spec2_r   <= spec_nxt;
      isspec2_r <= isspec_nxt;
      sign2_r   <= big[31];
      zsign2_r  <= a1_r[31] & b1_r[31];
      sub2_r    <= a1_r[31] ^ b1_r[31];
      exp2_r    <= big[30:23];
      ml2_r     <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
      ms2_r     <= ms_nxt;
    end
  end

  // Stage 3: magnitude add or subtract.
  always_comb begin
    if (sub2_r) sum_nxt = {1'b0, ml2_r} - {1'b0, ms2_r};
    else        sum_nxt = {1'b0, ml2_r} + {1'b0, ms2_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      spec3_r   <= spec2_r;
      isspec3_r <= isspec2_r;
      sign3_r   <= sign2_r;
      zsign3_r  <= zsign2_r;
      exp3_r    <= exp2_r;
      sum3_r    <= sum_nxt;
    end
  end

  // Stage 4: normalize so the leading one sits at the top of the significand.
  always_comb begin
    lz = clz_ext(sum3_r[MANT_EXT_W-1:0]);
    if (sum3_r[SUM_W-1]) begin
      nm_nxt = {sum3_r[SUM_W-1:2], sum3_r[1] | sum3_r[0]};
      ne_nxt = $signed({2'b00, exp3_r}) + 10'sd1;
    end else begin
      nm_nxt = sum3_r[MANT_EXT_W-1:0] << lz;
      ne_nxt = $signed({2'b00, exp3_r}) - $signed({5'd0, lz});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      spec4_r   <= spec3_r;
      isspec4_r <= isspec3_r;
      sign4_r   <= sign3_r;
      zsign4_r  <= zsign3_r;
      zero4_r   <= (sum3_r == '0);
      nm4_r     <= nm_nxt;
      ne4_r     <= ne_nxt;
    end
  end

  // Stage 5: round to nearest even, flush tiny sums, saturate to infinity.
  always_comb begin
    rup = nm4_r[2] & (nm4_r[1] | nm4_r[0] | nm4_r[3]);
    rnd = {1'b0, nm4_r[MANT_EXT_W-1:3]} + {24'd0, rup};
    er  = ne4_r + $signed({9'd0, rnd[24]});
    if (isspec4_r) s5_nxt = spec4_r;
    else if (zero4_r) s5_nxt = {zsign4_r, 31'd0};
    else if (ne4_r <= 10'sd0) s5_nxt = {sign4_r, 31'd0};
    else if (er >= 10'sd255) s5_nxt = {sign4_r, INF_MAG};
    else s5_nxt = {sign4_r, er[7:0], rnd[22:0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      s5_r <= s5_nxt;
    end
  end

  // Narrow back to the element format; registered in the merge stage.
  assign sum_elem = (ctl.wire_format == WF_HALF) ? f32_to_half(s5_r) : narrow_bf16(s5_r);

endmodule

/* src/hwfva_ctrl.sv */
// Pipeline controller: per-stage valid bits, advance chain, flag pipe and format register.
`timescale 1ns / 1ps

module hwfva_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_stall,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  output hwfva_pkg::pipe_ctl_t ctl
);
  import hwfva_pkg::*;

  logic [PIPE_STAGES-1:0] vld_r, vld_nxt;
  logic [PIPE_STAGES-1:0] last_r;
  logic [PIPE_STAGES-1:0] adv;
  logic                   wire_format_r;

  // A stage may load when it is empty or its beat moves on.
  always_comb begin
    adv[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  // Valid bits follow their beats down the pipe.
  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= '0;
      wire_format_r <= WF_BF16;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        wire_format_r <= cfg_wr_data;
      end
    end
  end

  // Chunk-end flag rides alongside the lane data.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      last_r[0] <= in_last;
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (adv[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  assign in_stall        = !adv[0];
  assign out_valid       = vld_r[PIPE_STAGES-1];
  assign out_last        = last_r[PIPE_STAGES-1];
  assign ctl.adv         = adv;
  assign ctl.wire_format = wire_format_r;

  // An empty output stage never holds off the input.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[PIPE_STAGES-1] |-> !in_stall)
    else $error("input stalled while output stage is empty");

  // An accepted beat occupies the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");

  // A stalled result stays in the output stage.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE_STAGES-1] && out_stall) |=> (vld_r[PIPE_STAGES-1] && $stable(out_last)))
    else $error("stalled result dropped");

  // Format writes take effect on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (wire_format_r == $past(cfg_wr_data)))
    else $error("format register write lost");

endmodule

/* src/half_width_float_vector_add.sv */
// Top level: packed half-width float vector adder with lanes and merged output register.
`timescale 1ns / 1ps

// Adds two packed vectors of 16-bit floats lane by lane, bfloat16 or IEEE half as set by
// the one-bit format register (0 bfloat16, 1 half; reset 0), which must be written by the
// user only while the block is idle; the block itself does not enforce this. Each lane
// widens its operands to single precision, adds them with round to nearest even and
// narrows the sum: bfloat16 flushes denormals and narrows with ties away from zero, half
// narrows with round to nearest even. One vector is accepted every cycle unless in_stall
// is high; a result appears after its beat passes the five adder stages of each lane
// and the output register that merges the lanes. Lanes at and above LANES return zero.
module half_width_float_vector_add #(
  parameter int LANES = hwfva_pkg::DEF_LANES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hwfva_pkg::VEC_W-1:0]   in_acc_lanes,
  input  logic [hwfva_pkg::VEC_W-1:0]   in_add_lanes,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hwfva_pkg::VEC_W-1:0]   out_sum_lanes,
  output logic                          out_last_out,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);
  import hwfva_pkg::*;

  pipe_ctl_t                           ctl;
  logic [MAX_LANES-1:0][ELEM_W-1:0]    lane_sum;
  logic [VEC_W-1:0]                    sum_r;

  hwfva_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last     (in_last),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_last    (out_last_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl)
  );

  // One adder per active lane; unused lanes read as zero.
  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    if (i < LANES) begin : g_on
      hwfva_lane u_lane (
        .clk      (clk),
        .ctl      (ctl),
        .acc_elem (in_acc_lanes[i*ELEM_W +: ELEM_W]),
        .add_elem (in_add_lanes[i*ELEM_W +: ELEM_W]),
        .sum_elem (lane_sum[i])
      );
    end else begin : g_off
      assign lane_sum[i] = '0;
    end
  end

  // Merge stage: gather the lane sums into the output register.
  always_ff @(posedge clk) begin
    if (ctl.adv[PIPE_STAGES-1]) begin
      sum_r <= lane_sum;
    end
  end

  assign out_sum_lanes = sum_r;

endmodule

/* bench/half_width_float_vector_add_tb.sv */
// Self-checking testbench for the packed half-width float vector adder.
`timescale 1ns / 1ps

module half_width_float_vector_add_tb;
  import hwfva_pkg::*;

  localparam int LANE_COUNT = DEF_LANES;
  localparam int HOLD_LEN   = 60;

  typedef struct {
    logic [VEC_W-1:0] sum_lanes;
    logic             last_out;
  } lane_sum_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [VEC_W-1:0] in_acc_lanes;
  logic [VEC_W-1:0] in_add_lanes;
  logic             in_last;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VEC_W-1:0] out_sum_lanes;
  logic             out_last_out;
  logic             cfg_wr_en;
  logic             cfg_wr_data;

  lane_sum_t pending_sums[$];
  logic      cur_format;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles = 0;
  bit        hold_toggle = 1'b0;
  bit        hold_seen = 1'b0;
  int        mismatch_count = 0;
  bit        orphan_seen = 1'b0;

  half_width_float_vector_add #(.LANES(LANE_COUNT)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_acc_lanes(in_acc_lanes), .in_add_lanes(in_add_lanes), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sum_lanes(out_sum_lanes), .out_last_out(out_last_out),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Single precision add of two non-NaN operands, round to nearest even.
  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [8:0]  ea, eb;
    logic [27:0] ma, mb, acc;
    logic [24:0] rnd;
    logic [2:0]  grs;
    int          d;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    // Larger magnitude goes first.
    if (b[30:0] > a[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    ma = {1'b0, (a[30:23] != 8'd0), a[22:0], 3'b000};
    mb = {1'b0, (b[30:23] != 8'd0), b[22:0], 3'b000};
    d  = int'(ea) - int'(eb);
    if (d >= 27) mb = {27'd0, (mb != 28'd0)};
    else if (d > 0) mb = (mb >> d) | {27'd0, |(mb & ((28'd1 << d) - 28'd1))};
    acc = (a[31] == b[31]) ? ma + mb : ma - mb;
    if (acc == 28'd0) return {a[31] & b[31], 31'd0};
    // Normalize, keeping a sticky bit on a right shift.
    if (acc[27]) begin
      acc = (acc >> 1) | {27'd0, acc[0]};
      ea  = ea + 9'd1;
    end else begin
      while (!acc[26] && ea > 9'd1) begin
        acc = acc << 1;
        ea  = ea - 9'd1;
      end
    end
    rnd = {1'b0, acc[26:3]};
    grs = acc[2:0];
    if (grs > 3'd4 || (grs == 3'd4 && rnd[0])) rnd = rnd + 25'd1;
    if (rnd[24]) begin
      rnd = rnd >> 1;
      ea  = ea + 9'd1;
    end
    if (ea >= 9'd255) return {a[31], 8'hFF, 23'd0};
    return {a[31], rnd[23] ? ea[7:0] : 8'd0, rnd[22:0]};
  endfunction

  function automatic logic [31:0] lane_fp32_sum(input logic [31:0] a, input logic [31:0] b,
                                                input bit flush);
    logic [31:0] s;
    if (flush && a[30:23] == 8'd0) a = {a[31], 31'd0};
    if (flush && b[30:23] == 8'd0) b = {b[31], 31'd0};
    // Accumulator NaN wins over contribution NaN, both quieted.
    if (a[30:23] == 8'hFF && a[22:0] != 23'd0) return a | QNAN_BIT;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return b | QNAN_BIT;
    if (a[30:0] == INF_MAG && b[30:0] == INF_MAG && a[31] != b[31]) return DEFAULT_NAN;
    s = sp_add(a, b);
    if (flush && s[30:23] == 8'd0) s = {s[31], 31'd0};
    return s;
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [10:0] frac;
    logic [7:0]  ex;
    frac = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (frac == 11'd0) return {h[15], 31'd0};
      ex = 8'd113;
      while (!frac[10]) begin
        frac = frac << 1;
        ex   = ex - 8'd1;
      end
      return {h[15], ex, frac[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
  endfunction

  function automatic logic [15:0] narrow_half(input logic [31:0] x);
    int unsigned full, sh, q, rem, halfway;
    int          e;
    if (x[30:23] == 8'hFF) begin
      if (x[22:0] != 23'd0) return {x[31], 5'h1F, 1'b1, x[21:13]};
      return {x[31], 15'h7C00};
    end
    if (x[30:23] == 8'd0) return {x[31], 15'd0};
    e = int'(x[30:23]) - 112;
    if (e >= 31) return {x[31], 15'h7C00};
    full = {8'd0, 1'b1, x[22:0]};
    if (e >= 1) begin
      q   = (e << 10) | (full[22:0] >> 13);
      rem = full & 32'h1FFF;
      if (rem > 32'h1000 || (rem == 32'h1000 && q[0])) q++;
      return {x[31], q[14:0]};
    end
    // Lands in the half subnormal range.
    sh = 14 - e;
    if (sh > 24) return {x[31], 15'd0};
    q       = full >> sh;
    rem     = full & ((32'd1 << sh) - 1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && q[0])) q++;
    return {x[31], q[14:0]};
  endfunction

  function automatic logic [VEC_W-1:0] predict_vector_sum(input logic [VEC_W-1:0] acc,
                                                         input logic [VEC_W-1:0] add,
                                                         input logic fmt);
    logic [VEC_W-1:0] sum;
    logic [31:0]      s;
    sum = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      if (fmt == WF_HALF) begin
        s = lane_fp32_sum(widen_half(acc[16*i +: 16]), widen_half(add[16*i +: 16]), 1'b0);
        sum[16*i +: 16] = narrow_half(s);
      end else begin
        s = lane_fp32_sum({acc[16*i +: 16], 16'd0}, {add[16*i +: 16], 16'd0}, 1'b1);
        s = s + BF16_ROUND_ADD;
        sum[16*i +: 16] = s[31:16];
      end
    end
    return sum;
  endfunction

  // Random lane value biased toward the exponent extremes of the current format.
  function automatic logic [15:0] random_lane(input logic fmt);
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(5))
      0: if (fmt == WF_HALF) v[14:10] = 5'h1F; else v[14:7] = 8'hFF;
      1: if (fmt == WF_HALF) v[14:10] = 5'h00; else v[14:7] = 8'h00;
      2: if (fmt == WF_HALF) v[14:10] = 5'h1E; else v[14:7] = 8'hFE;
      default: ;
    endcase
    return v;
  endfunction

  // Sends one beat, idling first at random, and records its expected sum on acceptance.
  // Valid stays high after acceptance until the next beat or an idle cycle replaces it.
  task automatic send_vector(input logic [VEC_W-1:0] acc, input logic [VEC_W-1:0] add,
                             input logic last);
    lane_sum_t exp_sum;
    bit        stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_acc_lanes <= acc;
    in_add_lanes <= add;
    in_last      <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    exp_sum.sum_lanes = predict_vector_sum(acc, add, cur_format);
    exp_sum.last_out  = last;
    pending_sums.push_back(exp_sum);
  endtask

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
    send_vector({4{a}}, {4{b}}, 1'(($urandom_range(1))));
  endtask

  task automatic send_random_vector();
    logic [VEC_W-1:0] acc, add;
    for (int i = 0; i < 4; i++) begin
      acc[16*i +: 16] = random_lane(cur_format);
      // Sometimes the contribution cancels or nearly cancels the accumulator.
      case ($urandom_range(4))
        0: add[16*i +: 16] = acc[16*i +: 16] ^ 16'h8000;
        1: add[16*i +: 16] = (acc[16*i +: 16] ^ 16'h8000) + 16'($urandom_range(3));
        default: add[16*i +: 16] = random_lane(cur_format);
      endcase
    end
    send_vector(acc, add, 1'($urandom_range(1)));
  endtask

  task automatic drain_sums();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (PIPE_STAGES + 4) @(posedge clk);
  endtask

  // Register write while the block is idle.
  task automatic set_wire_format(input logic fmt);
    drain_sums();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_format  = fmt;
  endtask

  task automatic test_bf16_special_cases();
    set_wire_format(WF_BF16);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h0001, 16'h007F);
    send_pair(16'h3F80, 16'h3F80);
    send_pair(16'h7F80, 16'hFF80);
    send_pair(16'h7F81, 16'hFFC5);
    send_pair(16'h3F80, 16'h7FA0);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h7F7F, 16'h7F7F);
    send_pair(16'h0080, 16'h8081);
    send_pair(16'h3F81, 16'h3B80);
    send_vector(64'h7F80_FF80_0000_3F80, 64'h3F80_3F80_8000_BF80, 1'b1);
  endtask

  task automatic test_half_special_cases();
    set_wire_format(WF_HALF);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'h03FF, 16'h0001);
    send_pair(16'h7BFF, 16'h7BFF);
    send_pair(16'h7C00, 16'hFC00);
    send_pair(16'h7C01, 16'h7DFF);
    send_pair(16'h3C00, 16'hFFFF);
    send_pair(16'h3C00, 16'h1000);
    send_pair(16'h3C01, 16'hBC00);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_vector(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b0);
  endtask

  task automatic test_random_traffic(input logic fmt, input int count, input int s_pct,
                                     input int r_pct);
    set_wire_format(fmt);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_random_vector();
  endtask

  // Long receiver hold-off so the pipeline fills and stalls its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_toggle   = ~hold_toggle;
    repeat (40) send_random_vector();
  endtask

  // Receiver stall, with a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      out_stall   <= 1'b1;
      hold_cycles <= HOLD_LEN - 1;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest expected sum.
  always @(negedge clk) begin
    lane_sum_t exp_sum;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        orphan_seen = 1'b1;
        $display("unexpected result beat: sum %h last %b", out_sum_lanes, out_last_out);
      end else begin
        exp_sum = pending_sums.pop_front();
        if (out_sum_lanes !== exp_sum.sum_lanes || out_last_out !== exp_sum.last_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected sum %h last %b, got sum %h last %b",
                     exp_sum.sum_lanes, exp_sum.last_out, out_sum_lanes, out_last_out);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_acc_lanes   = '0;
    in_add_lanes   = '0;
    in_last        = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    cur_format     = WF_BF16;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bf16_special_cases();
    test_half_special_cases();
    test_random_traffic(WF_BF16, 150, 17, 52);
    test_random_traffic(WF_HALF, 150, 52, 17);
    test_random_traffic(WF_BF16, 110, 0, 0);
    test_random_traffic(WF_HALF, 110, 0, 0);
    test_output_backpressure();
    test_random_traffic(WF_BF16, 40, 10, 10);
    drain_sums();

    if (mismatch_count == 0 && !orphan_seen) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
src/hwfva_pkg.sv
src/hwfva_lane.sv
src/hwfva_ctrl.sv
src/half_width_float_vector_add.sv
bench/half_width_float_vector_add_tb.sv
